/* sv/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes and the CRC8 helper shared by the one-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_FIN  = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_GAP   = 4'd5,
        PH_WR_REC   = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_REC   = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_WAIT   = 3'd1,
        REG_PRESENCE_FINISH = 3'd2,
        REG_WR_ZERO_LOW     = 3'd3,
        REG_WR_ONE_LOW      = 3'd4,
        REG_WR_RECOVERY     = 3'd5,
        REG_RD_SAMPLE       = 3'd6,
        REG_RD_RECOVERY     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] presence_wait;
        logic [9:0] presence_finish;
        logic [7:0] wr_zero_low;
        logic [7:0] wr_one_low;
        logic [7:0] wr_recovery;
        logic [7:0] rd_sample;
        logic [7:0] rd_recovery;
    } t_cfg;

    typedef struct packed {
        logic       line_level;
        logic       cmd_valid;
        logic [1:0] req_type;
        logic [7:0] wr_byte;
    } t_tick;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_ok;
        logic [7:0] rd_byte;
        logic [7:0] crc_value;
        logic       cmd_dropped;
    } t_result;

    // Dallas CRC8, reflected, one byte LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c   = crc_in;
        d   = data;
        mix = 1'b0;
        for (int j = 0; j < 8; j++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

/* sv/owbm_seq.sv */
// ----------------------------------------------------------------------------
// owbm_seq
// Slot sequencer: phase, tick timer, bit shifter and CRC, one tick per beat.
// ----------------------------------------------------------------------------
module owbm_seq #(
    parameter int TIMER_BITS       = 10,
    parameter int READ_START_TICKS = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  owbm_pkg::t_cfg    i_cfg,
    input  owbm_pkg::t_tick   i_tick,
    output owbm_pkg::t_result o_result
);
    import owbm_pkg::*;

    localparam int DW = (TIMER_BITS > 10) ? TIMER_BITS : 10;
    localparam logic [DW-1:0] TMAX = DW'((1 << TIMER_BITS) - 1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);
    localparam logic [TIMER_BITS-1:0] RD_START  = TIMER_BITS'(READ_START_TICKS);

    // zero acts as one tick, long values saturate
    function automatic logic [TIMER_BITS-1:0] dur(input logic [9:0] v);
        logic [DW-1:0] w;
        w = DW'(v);
        if (w == '0) begin
            w = DW'(1);
        end
        if (w > TMAX) begin
            w = TMAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    t_phase                r_phase,    n_phase;
    logic [TIMER_BITS-1:0] r_timer,    n_timer;
    logic [2:0]            r_bit_cnt,  n_bit_cnt;
    logic [7:0]            r_shift,    n_shift;
    t_op                   r_op,       n_op;
    logic                  r_presence, n_presence;
    logic [7:0]            r_rd_byte,  n_rd_byte;
    logic [7:0]            r_crc,      n_crc;
    logic                  n_done;

    logic                  drive;
    logic                  busy;
    logic                  dropped;

    logic [TIMER_BITS-1:0] zero_len;
    logic [TIMER_BITS-1:0] one_len;
    logic [7:0]            wr_shifted;

    assign zero_len   = dur({2'b00, i_cfg.wr_zero_low});
    assign one_len    = dur({2'b00, i_cfg.wr_one_low});
    assign wr_shifted = {1'b0, r_shift[7:1]};

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_op       = r_op;
        n_presence = r_presence;
        n_rd_byte  = r_rd_byte;
        n_crc      = r_crc;
        n_done     = 1'b0;

        if (r_phase != PH_IDLE) begin
            if (r_timer > TIMER_ONE) begin
                n_timer = r_timer - TIMER_ONE;
            end else begin
                case (r_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_timer = dur({2'b00, i_cfg.presence_wait});
                    end
                    PH_RST_WAIT: begin
                        n_presence = ~i_tick.line_level;
                        n_phase    = PH_RST_FIN;
                        n_timer    = dur(i_cfg.presence_finish);
                    end
                    PH_RST_FIN: begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        n_done  = 1'b1;
                    end
                    PH_WR_LOW: begin
                        if (r_shift[0] && (zero_len > one_len)) begin
                            n_phase = PH_WR_GAP;
                            n_timer = zero_len - one_len;
                        end else begin
                            n_phase = PH_WR_REC;
                            n_timer = dur({2'b00, i_cfg.wr_recovery});
                        end
                    end
                    PH_WR_GAP: begin
                        n_phase = PH_WR_REC;
                        n_timer = dur({2'b00, i_cfg.wr_recovery});
                    end
                    PH_WR_REC, PH_RD_REC: begin
                        if (r_phase == PH_WR_REC) begin
                            n_shift = wr_shifted;
                        end
                        if (r_bit_cnt == 3'd7) begin
                            if (r_op == OP_READ) begin
                                n_rd_byte = r_shift;
                                n_crc     = crc8_byte(r_crc, r_shift);
                            end
                            n_phase   = PH_IDLE;
                            n_timer   = '0;
                            n_bit_cnt = '0;
                            n_done    = 1'b1;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                            if (r_op == OP_WRITE) begin
                                n_phase = PH_WR_LOW;
                                n_timer = wr_shifted[0] ? one_len : zero_len;
                            end else begin
                                n_phase = PH_RD_LOW;
                                n_timer = RD_START;
                            end
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = dur({2'b00, i_cfg.rd_sample});
                    end
                    PH_RD_WAIT: begin
                        n_shift = {i_tick.line_level, r_shift[7:1]};
                        n_phase = PH_RD_REC;
                        n_timer = dur({2'b00, i_cfg.rd_recovery});
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                    end
                endcase
            end
        end else if (i_tick.cmd_valid) begin
            case (i_tick.req_type)
                OP_RESET: begin
                    n_op      = OP_RESET;
                    n_bit_cnt = '0;
                    n_crc     = '0;
                    n_phase   = PH_RST_LOW;
                    n_timer   = dur(i_cfg.reset_low);
                end
                OP_WRITE: begin
                    n_op      = OP_WRITE;
                    n_bit_cnt = '0;
                    n_shift   = i_tick.wr_byte;
                    n_phase   = PH_WR_LOW;
                    n_timer   = i_tick.wr_byte[0] ? one_len : zero_len;
                end
                OP_READ: begin
                    n_op      = OP_READ;
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_phase   = PH_RD_LOW;
                    n_timer   = RD_START;
                end
                default: begin
                    // unknown request: ignore silently
                end
            endcase
        end
    end

    // tick outputs from the current phase
    always_comb begin
        drive   = 1'b0;
        busy    = 1'b0;
        dropped = 1'b0;
        if (r_phase != PH_IDLE) begin
            busy    = 1'b1;
            dropped = i_tick.cmd_valid;
            drive   = (r_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW});
        end else if (i_tick.cmd_valid && (i_tick.req_type inside {OP_RESET, OP_WRITE, OP_READ})) begin
            busy = 1'b1;
        end
    end

    always_comb begin
        o_result.drive_low   = drive;
        o_result.busy_res    = busy;
        o_result.done_res    = n_done;
        o_result.presence_ok = n_presence;
        o_result.rd_byte     = n_rd_byte;
        o_result.crc_value   = n_crc;
        o_result.cmd_dropped = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_op       <= OP_RESET;
            r_presence <= 1'b0;
            r_rd_byte  <= '0;
            r_crc      <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_op       <= n_op;
            r_presence <= n_presence;
            r_rd_byte  <= n_rd_byte;
            r_crc      <= n_crc;
        end
    end

endmodule

/* sv/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: reset/presence, byte write, byte read with CRC8.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-----------------------------------
//  in      | to block  | i_in_valid/o_in_stall | one tick: level + optional command
//  out     | from block| o_out_valid/i_out_stall| one result per tick
//  cfg     | to block  | i_cfg_valid/o_cfg_ready| register index + data
//
//  One tick per clock cycle while o_in_stall is low; the result of a tick is
//  registered and appears the cycle after it is accepted.
//  The output register takes a new result while its old one is being taken,
//  so o_in_stall rises only when that register is full and i_out_stall is high.
//  Synchronous active-low reset returns the sequencer to idle and the timing
//  registers to their defaults; o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int TIMER_BITS       = 10,
    parameter int READ_START_TICKS = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_line_level,
    input  logic                              i_cmd_valid,
    input  logic [1:0]                        i_req_type,
    input  logic [7:0]                        i_wr_byte,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_drive_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_presence_ok,
    output logic [7:0]                        o_rd_byte,
    output logic [7:0]                        o_crc_value,
    output logic                              o_cmd_dropped,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import owbm_pkg::*;

    t_cfg    r_cfg;
    t_tick   tick;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign tick.line_level = i_line_level;
    assign tick.cmd_valid  = i_cmd_valid;
    assign tick.req_type   = i_req_type;
    assign tick.wr_byte    = i_wr_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low       <= 10'd480;
            r_cfg.presence_wait   <= 8'd70;
            r_cfg.presence_finish <= 10'd410;
            r_cfg.wr_zero_low     <= 8'd60;
            r_cfg.wr_one_low      <= 8'd1;
            r_cfg.wr_recovery     <= 8'd5;
            r_cfg.rd_sample       <= 8'd14;
            r_cfg.rd_recovery     <= 8'd45;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RESET_LOW:       r_cfg.reset_low       <= i_cfg_data;
                REG_PRESENCE_WAIT:   r_cfg.presence_wait   <= i_cfg_data[7:0];
                REG_PRESENCE_FINISH: r_cfg.presence_finish <= i_cfg_data;
                REG_WR_ZERO_LOW:     r_cfg.wr_zero_low     <= i_cfg_data[7:0];
                REG_WR_ONE_LOW:      r_cfg.wr_one_low      <= i_cfg_data[7:0];
                REG_WR_RECOVERY:     r_cfg.wr_recovery     <= i_cfg_data[7:0];
                REG_RD_SAMPLE:       r_cfg.rd_sample       <= i_cfg_data[7:0];
                REG_RD_RECOVERY:     r_cfg.rd_recovery     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    owbm_seq #(
        .TIMER_BITS       (TIMER_BITS),
        .READ_START_TICKS (READ_START_TICKS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_accept),
        .i_cfg    (r_cfg),
        .i_tick   (tick),
        .o_result (result)
    );

    // output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_low   = r_out.drive_low;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_presence_ok = r_out.presence_ok;
    assign o_rd_byte     = r_out.rd_byte;
    assign o_crc_value   = r_out.crc_value;
    assign o_cmd_dropped = r_out.cmd_dropped;

endmodule

/* sv/owbm_chk.sv */
// ----------------------------------------------------------------------------
// owbm_chk
// Port-level checks for the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_drive_low,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rd_byte,
    input logic [7:0] o_crc_value,
    input logic       o_cmd_dropped
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rd_byte)
            && $stable(o_crc_value) && $stable(o_done_res))
        else $error("stalled result changed");

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res && !o_done_res)
        else $error("bus driven outside an active slot");

    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cmd_dropped |-> o_busy_res)
        else $error("command dropped while idle");

endmodule

bind one_wire_bus_master owbm_chk u_owbm_chk (.*);

/* tb/tb_one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the one-wire bus master. A tick-level model of the
// slot sequencer predicts every result beat; stimulus covers a read at default
// timing, reset/presence, byte writes and reads at zero, upper-bit and random
// slot timings, commands while busy, unknown requests, random idle/stall on both sides.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam int TB_TIMER_BITS   = 10;
    localparam int TB_READ_START   = 1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int LINE_RANDOM = 0;
    localparam int LINE_LOW    = 1;
    localparam int LINE_HIGH   = 2;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   i_line_level = 1'b1;
    logic                   i_cmd_valid  = 1'b0;
    logic [1:0]             i_req_type   = 2'd0;
    logic [7:0]             i_wr_byte    = 8'd0;
    logic                   i_out_stall  = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_drive_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_presence_ok;
    logic [7:0] o_rd_byte;
    logic [7:0] o_crc_value;
    logic       o_cmd_dropped;
    logic       o_cfg_ready;

    one_wire_bus_master #(
        .TIMER_BITS       (TB_TIMER_BITS),
        .READ_START_TICKS (TB_READ_START)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_line_level  (i_line_level),
        .i_cmd_valid   (i_cmd_valid),
        .i_req_type    (i_req_type),
        .i_wr_byte     (i_wr_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive_low   (o_drive_low),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_presence_ok (o_presence_ok),
        .o_rd_byte     (o_rd_byte),
        .o_crc_value   (o_crc_value),
        .o_cmd_dropped (o_cmd_dropped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Slot sequencer model
    // ------------------------------------------------------------------
    t_phase      bus_phase;
    int unsigned slot_left;
    logic [2:0]  bit_idx;
    logic [7:0]  shift_reg;
    t_op         cur_op;
    logic        presence_seen;
    logic [7:0]  last_rd_byte;
    logic [7:0]  crc_run;
    logic [9:0]  timing_regs [8];

    t_result tick_results_q [$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_off_req  = 0;
    int hold_off_left = 0;
    int ticks_sent    = 0;
    int fail_count    = 0;
    int result_count  = 0;
    int cycle_count   = 0;

    function automatic void bus_model_reset();
        bus_phase     = PH_IDLE;
        slot_left     = 0;
        bit_idx       = '0;
        shift_reg     = '0;
        cur_op        = OP_RESET;
        presence_seen = 1'b0;
        last_rd_byte  = '0;
        crc_run       = '0;
        timing_regs[REG_RESET_LOW]       = 10'd480;
        timing_regs[REG_PRESENCE_WAIT]   = 10'd70;
        timing_regs[REG_PRESENCE_FINISH] = 10'd410;
        timing_regs[REG_WR_ZERO_LOW]     = 10'd60;
        timing_regs[REG_WR_ONE_LOW]      = 10'd1;
        timing_regs[REG_WR_RECOVERY]     = 10'd5;
        timing_regs[REG_RD_SAMPLE]       = 10'd14;
        timing_regs[REG_RD_RECOVERY]     = 10'd45;
    endfunction

    // zero counts as one tick, anything past the timer range saturates
    function automatic int unsigned slot_len(input int unsigned ticks);
        int unsigned cap;
        cap = (1 << TB_TIMER_BITS) - 1;
        if (ticks == 0) return 1;
        if (ticks > cap) return cap;
        return ticks;
    endfunction

    function automatic void enter_slot(input t_phase p, input int unsigned ticks);
        bus_phase = p;
        slot_left = slot_len(ticks);
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            fb  = acc[0] ^ data[k];
            acc = (acc >> 1) ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // returns 1 once the last bit slot of the byte has ended
    function automatic logic advance_bit();
        if (bit_idx == 3'd7) begin
            if (cur_op == OP_READ) begin
                last_rd_byte = shift_reg;
                crc_run      = crc8_update(crc_run, shift_reg);
            end
            bus_phase = PH_IDLE;
            slot_left = 0;
            bit_idx   = '0;
            return 1'b1;
        end
        bit_idx = bit_idx + 3'd1;
        if (cur_op == OP_WRITE)
            enter_slot(PH_WR_LOW, shift_reg[0] ? timing_regs[REG_WR_ONE_LOW]
                                               : timing_regs[REG_WR_ZERO_LOW]);
        else
            enter_slot(PH_RD_LOW, TB_READ_START);
        return 1'b0;
    endfunction

    function automatic t_result predict_bus_tick(input t_tick tk);
        t_result     r;
        int unsigned zero_len;
        int unsigned one_len;
        r = '0;
        if (bus_phase != PH_IDLE) begin
            r.busy_res    = 1'b1;
            r.drive_low   = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                            (bus_phase == PH_RD_LOW);
            r.cmd_dropped = tk.cmd_valid;
            if (slot_left > 1) begin
                slot_left--;
            end else begin
                case (bus_phase)
                    PH_RST_LOW: enter_slot(PH_RST_WAIT, timing_regs[REG_PRESENCE_WAIT]);
                    PH_RST_WAIT: begin
                        presence_seen = ~tk.line_level;
                        enter_slot(PH_RST_FIN, timing_regs[REG_PRESENCE_FINISH]);
                    end
                    PH_RST_FIN: begin
                        bus_phase  = PH_IDLE;
                        slot_left  = 0;
                        r.done_res = 1'b1;
                    end
                    PH_WR_LOW: begin
                        zero_len = slot_len(timing_regs[REG_WR_ZERO_LOW]);
                        one_len  = slot_len(timing_regs[REG_WR_ONE_LOW]);
                        if (shift_reg[0] && zero_len > one_len)
                            enter_slot(PH_WR_GAP, zero_len - one_len);
                        else
                            enter_slot(PH_WR_REC, timing_regs[REG_WR_RECOVERY]);
                    end
                    PH_WR_GAP: enter_slot(PH_WR_REC, timing_regs[REG_WR_RECOVERY]);
                    PH_WR_REC: begin
                        shift_reg  = shift_reg >> 1;
                        r.done_res = advance_bit();
                    end
                    PH_RD_LOW: enter_slot(PH_RD_WAIT, timing_regs[REG_RD_SAMPLE]);
                    PH_RD_WAIT: begin
                        shift_reg = {tk.line_level, shift_reg[7:1]};
                        enter_slot(PH_RD_REC, timing_regs[REG_RD_RECOVERY]);
                    end
                    PH_RD_REC: r.done_res = advance_bit();
                    default: begin
                        bus_phase = PH_IDLE;
                        slot_left = 0;
                    end
                endcase
            end
        end else if (tk.cmd_valid && tk.req_type <= OP_READ) begin
            r.busy_res = 1'b1;
            cur_op     = t_op'(tk.req_type);
            bit_idx    = '0;
            if (cur_op == OP_RESET) begin
                crc_run = '0;
                enter_slot(PH_RST_LOW, timing_regs[REG_RESET_LOW]);
            end else if (cur_op == OP_WRITE) begin
                shift_reg = tk.wr_byte;
                enter_slot(PH_WR_LOW, shift_reg[0] ? timing_regs[REG_WR_ONE_LOW]
                                                   : timing_regs[REG_WR_ZERO_LOW]);
            end else begin
                shift_reg = '0;
                enter_slot(PH_RD_LOW, TB_READ_START);
            end
        end
        r.presence_ok = presence_seen;
        r.rd_byte     = last_rd_byte;
        r.crc_value   = crc_run;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_drive_low, o_busy_res, o_done_res, o_presence_ok,
                   o_rd_byte, o_crc_value, o_cmd_dropped};
            if (tick_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result beat %0d arrived with nothing expected", result_count);
            end else begin
                want = tick_results_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result beat %0d: expected %h, got %h",
                                 result_count, want, got);
                end
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_tick(input logic line, input logic cmd, input logic [1:0] req,
                             input logic [7:0] wr);
        t_tick tk;
        tk = {line, cmd, req, wr};
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_line_level <= line;
        i_cmd_valid  <= cmd;
        i_req_type   <= req;
        i_wr_byte    <= wr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tick_results_q.push_back(predict_bus_tick(tk));
        ticks_sent++;
    endtask

    function automatic logic pick_line(input int mode);
        if (mode == LINE_LOW) return 1'b0;
        if (mode == LINE_HIGH) return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    // issue one command from idle and clock ticks until it completes
    task automatic run_cmd(input t_op op, input logic [7:0] wr, input int line_mode,
                           input int noise_pct);
        send_tick(pick_line(line_mode), 1'b1, op, wr);
        while (bus_phase != PH_IDLE)
            send_tick(pick_line(line_mode), ($urandom_range(99) < noise_pct),
                      2'($urandom_range(3)), 8'($urandom));
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(pick_line(LINE_RANDOM), 1'b0, 2'($urandom_range(3)),
                             8'($urandom));
    endtask

    // drop valid and wait until every predicted beat has come back
    task automatic wait_bus_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timing(input t_reg_idx idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_RESET_LOW || idx == REG_PRESENCE_FINISH)
            timing_regs[idx] = val;
        else
            timing_regs[idx] = {2'b00, val[7:0]};
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_timing_range(input int unsigned lo, input int unsigned hi);
        for (int k = 0; k < 8; k++)
            write_timing(t_reg_idx'(k), 10'($urandom_range(hi, lo)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_timing();
        // one read at the reset timing; longer slots run with short timings below
        run_cmd(OP_READ, 8'h00, LINE_RANDOM, 0);
        wait_bus_quiet();
    endtask

    task automatic test_unknown_and_busy();
        load_timing_range(1, 2);
        // unknown request at idle: no busy, no flag
        send_tick(1'b1, 1'b1, REQ_UNKNOWN, 8'hFF);
        idle_ticks(2);
        // every request type while busy is dropped
        run_cmd(OP_WRITE, 8'h3C, LINE_RANDOM, 100);
        wait_bus_quiet();
    endtask

    task automatic test_zero_timing();
        load_timing_range(0, 0);
        run_cmd(OP_RESET, 8'h00, LINE_HIGH, 0);
        run_cmd(OP_WRITE, 8'h5A, LINE_RANDOM, 0);
        run_cmd(OP_READ, 8'h00, LINE_LOW, 0);
        // reset clears the running CRC, presence holds until the new sample
        run_cmd(OP_RESET, 8'h00, LINE_LOW, 0);
        run_cmd(OP_READ, 8'h00, LINE_RANDOM, 0);
        wait_bus_quiet();
    endtask

    task automatic test_write_one_gap();
        write_timing(REG_WR_ZERO_LOW, 10'd2);
        write_timing(REG_WR_ONE_LOW, 10'd4);
        write_timing(REG_WR_RECOVERY, 10'd1);
        run_cmd(OP_WRITE, 8'hFF, LINE_RANDOM, 0);
        wait_bus_quiet();
        write_timing(REG_WR_ONE_LOW, 10'd2);
        run_cmd(OP_WRITE, 8'hAA, LINE_RANDOM, 0);
        wait_bus_quiet();
        write_timing(REG_WR_ZERO_LOW, 10'd4);
        write_timing(REG_WR_ONE_LOW, 10'd1);
        run_cmd(OP_WRITE, 8'h55, LINE_RANDOM, 0);
        wait_bus_quiet();
    endtask

    task automatic test_upper_bits();
        // set the unused upper data bits of the byte-wide registers
        write_timing(REG_RESET_LOW, 10'd2);
        write_timing(REG_PRESENCE_WAIT, 10'h302);
        write_timing(REG_PRESENCE_FINISH, 10'd3);
        write_timing(REG_WR_ZERO_LOW, 10'h303);
        write_timing(REG_WR_ONE_LOW, 10'h301);
        write_timing(REG_WR_RECOVERY, 10'h301);
        write_timing(REG_RD_SAMPLE, 10'h302);
        write_timing(REG_RD_RECOVERY, 10'h302);
        run_cmd(OP_RESET, 8'h00, LINE_RANDOM, 0);
        run_cmd(OP_WRITE, 8'h81, LINE_RANDOM, 0);
        run_cmd(OP_READ, 8'h00, LINE_RANDOM, 2);
        wait_bus_quiet();
    endtask

    task automatic test_backpressure();
        load_timing_range(1, 2);
        hold_off_req = 150;
        run_cmd(OP_WRITE, 8'($urandom), LINE_RANDOM, 5);
        run_cmd(OP_READ, 8'h00, LINE_RANDOM, 5);
        wait_bus_quiet();
    endtask

    task automatic test_random_traffic();
        int idle_pct  [4] = '{0, 52, 0, 23};
        int stall_pct [4] = '{0, 0, 52, 23};
        int start;
        int pick;
        for (int p = 0; p < 4; p++) begin
            load_timing_range(0, 2);
            tx_idle_pct  = idle_pct[p];
            rx_stall_pct = stall_pct[p];
            start = ticks_sent;
            while (ticks_sent - start < 30) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    run_cmd(t_op'($urandom_range(2)), 8'($urandom), LINE_RANDOM, 8);
                else if (pick < 93)
                    idle_ticks($urandom_range(4, 1));
                else
                    send_tick(pick_line(LINE_RANDOM), 1'b1, REQ_UNKNOWN, 8'($urandom));
            end
            wait_bus_quiet();
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        bus_model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_unknown_and_busy();
        test_zero_timing();
        test_write_one_gap();
        test_upper_bits();
        test_backpressure();
        test_random_traffic();

        wait_bus_quiet();
        if (fail_count == 0 && tick_results_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
